FILE: hw/rtl/sts_pkg.sv
// Package for the timed state sequencer: action, status and error codes,
// the result item and table access structs, and small helper functions.
// Depends on nothing.
`timescale 1ns / 1ps

package sts_pkg;

  localparam int MAX_STATES  = 16;
  localparam int NUM_STREAMS = 8;
  localparam int IDX_W       = $clog2(MAX_STATES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int TICK_W      = 32;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_START  = 3'd1,
    ACT_STOP   = 3'd2,
    ACT_PAUSE  = 3'd3,
    ACT_RESUME = 3'd4,
    ACT_LOAD   = 3'd5,
    ACT_TRIP   = 3'd6,
    ACT_NOP    = 3'd7
  } act_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_PAUSE = 5'b00100,
    ST_STOP  = 5'b01000,
    ST_DONE  = 5'b10000
  } status_t;

  typedef enum logic [2:0] {
    RS_IDLE  = 3'd0,
    RS_RUN   = 3'd1,
    RS_PAUSE = 3'd2,
    RS_STOP  = 3'd3,
    RS_DONE  = 3'd4
  } run_code_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BUSY       = 3'd1,
    ERR_NO_STATES  = 3'd2,
    ERR_NO_STREAMS = 3'd3,
    ERR_LOAD_BUSY  = 3'd4
  } err_t;

  typedef enum logic {
    CFG_STATE_COUNT = 1'b0,
    CFG_STREAM_MASK = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]        run_status;
    logic [IDX_W-1:0]  state_index;
    logic              index_valid;
    logic              entered;
    logic [TICK_W-1:0] state_ticks;
    logic [TICK_W-1:0] total_ticks;
    logic [2:0]        error_code;
    logic              trip_pending;
  } res_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [TICK_W-1:0] dur;
    logic              trip;
  } tbl_wr_t;

  typedef struct packed {
    logic [TICK_W-1:0] dur;
    logic              trip;
    logic              nxt_trip;
  } tbl_rd_t;

  function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
    return (v == {TICK_W{1'b1}}) ? v : v + {{(TICK_W-1){1'b0}}, 1'b1};
  endfunction

  function automatic logic [2:0] encode_status(input status_t s);
    run_code_t c;
    case (s)
      ST_IDLE:  c = RS_IDLE;
      ST_RUN:   c = RS_RUN;
      ST_PAUSE: c = RS_PAUSE;
      ST_STOP:  c = RS_STOP;
      ST_DONE:  c = RS_DONE;
      default:  c = RS_IDLE;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/sts_table.sv
// State table storage: duration and transition type per entry.
// Registered reads of the current entry and of the next entry's type; uses sts_pkg.
`timescale 1ns / 1ps

module sts_table
  import sts_pkg::*;
(
  input  logic             clk,
  input  tbl_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output tbl_rd_t          rd
);

  logic [TICK_W-1:0] dur_mem [MAX_STATES];
  logic              trip_mem [MAX_STATES];
  logic [IDX_W-1:0]  rd_addr_b;

  assign rd_addr_b = rd_addr + {{(IDX_W-1){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (wr.en) begin
      dur_mem[wr.idx]  <= wr.dur;
      trip_mem[wr.idx] <= wr.trip;
    end
  end

  always_ff @(posedge clk) begin
    rd.dur      <= dur_mem[rd_addr];
    rd.trip     <= trip_mem[rd_addr];
    rd.nxt_trip <= trip_mem[rd_addr_b];
  end

endmodule

FILE: hw/rtl/sts_ctrl.sv
// Sequencer control: run status, current entry, tick counters and trip latch,
// with the per-item next-state logic and result forming; uses sts_pkg.
`timescale 1ns / 1ps

module sts_ctrl
  import sts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   proc,
  input  act_t                   act,
  input  logic [IDX_W-1:0]       idx,
  input  logic [TICK_W-1:0]      dur,
  input  logic                   ttype,
  input  logic [CNT_W-1:0]       state_count,
  input  logic [NUM_STREAMS-1:0] stream_mask,
  input  tbl_rd_t                rd,
  output tbl_wr_t                wr,
  output logic [IDX_W-1:0]       rd_addr,
  output res_t                   res
);

  status_t           status_r, status_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic              valid_r, valid_nxt;
  logic [TICK_W-1:0] tis_r, tis_nxt;
  logic [TICK_W-1:0] tot_r, tot_nxt;
  logic              latch_r, latch_nxt;
  logic              busy;
  logic              done;
  logic              entered;
  err_t              err;
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  slot_plus;
  logic [TICK_W-1:0] tis_inc;

  assign busy      = (status_r == ST_RUN) || (status_r == ST_PAUSE);
  assign used      = (state_count > CNT_W'(MAX_STATES)) ? CNT_W'(MAX_STATES) : state_count;
  assign slot_plus = {1'b0, cur_r} + {{(CNT_W-1){1'b0}}, 1'b1};
  assign tis_inc   = sat_inc(tis_r);
  assign rd_addr   = cur_nxt;

  always_comb begin
    status_nxt = status_r;
    cur_nxt    = cur_r;
    valid_nxt  = valid_r;
    tis_nxt    = tis_r;
    tot_nxt    = tot_r;
    latch_nxt  = latch_r;
    err        = ERR_NONE;
    entered    = 1'b0;
    done       = 1'b0;
    wr.en      = 1'b0;
    wr.idx     = idx;
    wr.dur     = dur;
    wr.trip    = ttype;
    if (proc) begin
      case (act)
        ACT_TICK: begin
          if (busy && valid_r) begin
            tot_nxt = sat_inc(tot_r);
            tis_nxt = tis_inc;
            if (status_r == ST_RUN) begin
              if (rd.trip && latch_r) begin
                latch_nxt = 1'b0;
                done      = 1'b1;
              end else if (tis_inc >= rd.dur) begin
                done = 1'b1;
              end
              if (done) begin
                if (slot_plus < used) begin
                  cur_nxt   = slot_plus[IDX_W-1:0];
                  valid_nxt = 1'b1;
                  tis_nxt   = '0;
                  entered   = 1'b1;
                  if (rd.nxt_trip) begin
                    latch_nxt = 1'b0;
                  end
                end else begin
                  status_nxt = ST_DONE;
                  valid_nxt  = 1'b0;
                  cur_nxt    = '0;
                end
              end
            end
          end
        end
        ACT_START: begin
          if (busy) begin
            err = ERR_BUSY;
          end else if (used == '0) begin
            err = ERR_NO_STATES;
          end else if (stream_mask == '0) begin
            err = ERR_NO_STREAMS;
          end else begin
            status_nxt = ST_RUN;
            tot_nxt    = '0;
            tis_nxt    = '0;
            latch_nxt  = 1'b0;
            cur_nxt    = '0;
            valid_nxt  = 1'b1;
            entered    = 1'b1;
          end
        end
        ACT_STOP: begin
          if ((status_r != ST_IDLE) && (status_r != ST_STOP)) begin
            status_nxt = ST_STOP;
            valid_nxt  = 1'b0;
            cur_nxt    = '0;
          end
        end
        ACT_PAUSE: begin
          if (status_r == ST_RUN) begin
            status_nxt = ST_PAUSE;
          end
        end
        ACT_RESUME: begin
          if (status_r == ST_PAUSE) begin
            status_nxt = ST_RUN;
          end
        end
        ACT_LOAD: begin
          if (busy) begin
            err = ERR_LOAD_BUSY;
          end else begin
            wr.en = 1'b1;
          end
        end
        ACT_TRIP: begin
          latch_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.run_status   = encode_status(status_nxt);
    res.state_index  = valid_nxt ? cur_nxt : '0;
    res.index_valid  = valid_nxt;
    res.entered      = entered;
    res.state_ticks  = tis_nxt;
    res.total_ticks  = tot_nxt;
    res.error_code   = err;
    res.trip_pending = latch_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_IDLE;
      cur_r    <= '0;
      valid_r  <= 1'b0;
      tis_r    <= '0;
      tot_r    <= '0;
      latch_r  <= 1'b0;
    end else begin
      status_r <= status_nxt;
      cur_r    <= cur_nxt;
      valid_r  <= valid_nxt;
      tis_r    <= tis_nxt;
      tot_r    <= tot_nxt;
      latch_r  <= latch_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r == busy)
    else $error("Current entry flag disagrees with run status.");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r |-> (cur_r == '0))
    else $error("Entry index nonzero with no current entry.");

  a_enter_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && entered) |=> (tis_r == '0) && valid_r)
    else $error("Entering an entry did not clear its tick count.");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !busy)
    else $error("Table written while a sequence is active.");
`endif

endmodule

FILE: hw/rtl/timed_state_sequencer.sv
// Timed state sequencer top level: input register, configuration registers,
// control and table, result register. Uses sts_pkg, sts_ctrl and sts_table.
// An accepted item is held in the input register until the result register can
// take it, then processed; one item per cycle unless the output stalls.
// The rate is set by the single pass from input register to result register.
// Synchronous active-low reset clears status, counters and configuration; the
// state table is undefined until its entries are loaded.
`timescale 1ns / 1ps

module timed_state_sequencer
  import sts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             in_action,
  input  logic [IDX_W-1:0]       in_entry_index,
  input  logic [TICK_W-1:0]      in_entry_duration,
  input  logic                   in_entry_trip_type,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_run_status,
  output logic [IDX_W-1:0]       out_state_index,
  output logic                   out_index_valid,
  output logic                   out_entered,
  output logic [TICK_W-1:0]      out_state_ticks,
  output logic [TICK_W-1:0]      out_total_ticks,
  output logic [2:0]             out_error_code,
  output logic                   out_trip_pending,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [NUM_STREAMS-1:0] cfg_wdata
);

  logic                   in_vld_r, in_vld_nxt;
  act_t                   in_act_r;
  logic [IDX_W-1:0]       in_idx_r;
  logic [TICK_W-1:0]      in_dur_r;
  logic                   in_trip_r;
  logic                   out_vld_r, out_vld_nxt;
  res_t                   out_res_r;
  res_t                   res;
  logic [CNT_W-1:0]       state_count_r;
  logic [NUM_STREAMS-1:0] stream_mask_r;
  logic                   adv;
  logic                   proc;
  logic                   acc;
  tbl_wr_t                tbl_wr;
  tbl_rd_t                tbl_rd;
  logic [IDX_W-1:0]       tbl_addr;

  assign adv      = !out_vld_r || out_ready;
  assign proc     = in_vld_r && adv;
  assign in_ready = !in_vld_r || adv;
  assign acc      = in_valid && in_ready;

  assign in_vld_nxt  = acc ? 1'b1 : (proc ? 1'b0 : in_vld_r);
  assign out_vld_nxt = proc ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      in_act_r  <= act_t'(in_action);
      in_idx_r  <= in_entry_index;
      in_dur_r  <= in_entry_duration;
      in_trip_r <= in_entry_trip_type;
    end
    if (proc) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_count_r <= '0;
      stream_mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STATE_COUNT: state_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_STREAM_MASK: stream_mask_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  sts_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .proc        (proc),
    .act         (in_act_r),
    .idx         (in_idx_r),
    .dur         (in_dur_r),
    .ttype       (in_trip_r),
    .state_count (state_count_r),
    .stream_mask (stream_mask_r),
    .rd          (tbl_rd),
    .wr          (tbl_wr),
    .rd_addr     (tbl_addr),
    .res         (res)
  );

  sts_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (tbl_addr),
    .rd      (tbl_rd)
  );

  assign out_valid        = out_vld_r;
  assign out_run_status   = out_res_r.run_status;
  assign out_state_index  = out_res_r.state_index;
  assign out_index_valid  = out_res_r.index_valid;
  assign out_entered      = out_res_r.entered;
  assign out_state_ticks  = out_res_r.state_ticks;
  assign out_total_ticks  = out_res_r.total_ticks;
  assign out_error_code   = out_res_r.error_code;
  assign out_trip_pending = out_res_r.trip_pending;

endmodule
